// ===== src/seven_segment_command_formatter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// seven segment command formatter - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_COMMAND_FORMATTER_UNIT_MACROS_SVH
`define SEVEN_SEGMENT_COMMAND_FORMATTER_UNIT_MACROS_SVH

// same-cycle implication
`define SSCF_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSCF_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sscf_pkg.sv =====
// ----------------------------------------------------------------------------
// sscf_pkg
// types, character codes and the binary to bcd step for the formatter
// ----------------------------------------------------------------------------
`default_nettype none

package sscf_pkg;

  localparam int NUMBER_W      = 16;
  localparam int BYTE_W        = 8;
  localparam int MASK_W        = 6;
  localparam int BCD_DIGITS    = 5;
  localparam int ND_W          = 3;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = NUMBER_W / BITS_PER_STEP;
  localparam int CNT_W         = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_NUMBER = 1'b0;
  localparam logic CMD_DOTS   = 1'b1;

  localparam logic [BYTE_W-1:0] CHR_V     = 8'h76;
  localparam logic [BYTE_W-1:0] CHR_W     = 8'h77;
  localparam logic [BYTE_W-1:0] CHR_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_F     = 8'h46;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ZERO,
    KIND_WIDE,
    KIND_DOTS
  } kind_t;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  neg;
    logic [ND_W-1:0]       nd;
    logic [BYTE_W-1:0]     pad;
    bcd_t [BCD_DIGITS-1:0] digits;
    logic [MASK_W-1:0]     mask;
  } entry_t;

  // four double-dabble steps, msb of the nibble first
  function automatic logic [BCD_DIGITS*4-1:0] dabble_step(
    input logic [BCD_DIGITS*4-1:0] bcd_in,
    input logic [BITS_PER_STEP-1:0] bits
  );
    logic [BCD_DIGITS*4-1:0] acc;
    acc = bcd_in;
    for (int s = BITS_PER_STEP - 1; s >= 0; s--) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (acc[d*4 +: 4] >= 4'd5) begin
          acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
        end
      end
      acc = {acc[BCD_DIGITS*4-2:0], bits[s]};
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== src/sscf_cmd_if.sv =====
// ----------------------------------------------------------------------------
// sscf_cmd_if
// command channel: one beat is one display command
// ----------------------------------------------------------------------------
`default_nettype none

interface sscf_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic signed [sscf_pkg::NUMBER_W-1:0]  number;
  logic        [sscf_pkg::BYTE_W-1:0]    pad_byte;
  logic        [sscf_pkg::MASK_W-1:0]    dot_mask;

  modport source (output valid, command, number, pad_byte, dot_mask, input ready);
  modport sink   (input valid, command, number, pad_byte, dot_mask, output ready);
endinterface

`default_nettype wire

// ===== src/sscf_byte_if.sv =====
// ----------------------------------------------------------------------------
// sscf_byte_if
// display byte channel: one beat is one byte for the display
// ----------------------------------------------------------------------------
`default_nettype none

interface sscf_byte_if;
  logic                          valid;
  logic                          ready;
  logic [sscf_pkg::BYTE_W-1:0]   out_byte;
  logic                          last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== src/sscf_front.sv =====
// ----------------------------------------------------------------------------
// sscf_front
// takes command beats, converts the magnitude to bcd and classifies it
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_command_formatter_unit_macros.svh"

module sscf_front #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  sscf_cmd_if.sink          cmd,
  output logic              push_valid,
  input  logic              push_ready,
  output sscf_pkg::entry_t  push_data
);

  localparam logic [sscf_pkg::CNT_W-1:0] STEPS_DONE = sscf_pkg::CNT_W'(sscf_pkg::CONV_STEPS);

  logic                                   busy;
  logic [sscf_pkg::CNT_W-1:0]             cnt;
  logic [sscf_pkg::NUMBER_W-1:0]          shreg;
  logic [sscf_pkg::BCD_DIGITS*4-1:0]      bcd;
  logic                                   neg;
  logic                                   dots;
  logic [sscf_pkg::BYTE_W-1:0]            pad;
  logic [sscf_pkg::MASK_W-1:0]            mask;

  logic                                   done;
  logic                                   accept;
  logic [sscf_pkg::NUMBER_W-1:0]          raw;
  logic [sscf_pkg::NUMBER_W-1:0]          mag;
  logic [sscf_pkg::ND_W-1:0]              nd;
  logic                                   wide;

  assign done       = busy && (cnt == STEPS_DONE);
  assign push_valid = done;
  assign cmd.ready  = !busy || (done && push_ready);
  assign accept     = cmd.valid && cmd.ready;

  assign raw = cmd.number;
  assign mag = raw[sscf_pkg::NUMBER_W-1] ? (~raw + 16'd1) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      cnt  <= (cmd.command == sscf_pkg::CMD_DOTS) ? STEPS_DONE : '0;
    end else if (done && push_ready) begin
      busy <= 1'b0;
    end else if (busy && !done) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= mag;
      bcd   <= '0;
      neg   <= raw[sscf_pkg::NUMBER_W-1];
      dots  <= (cmd.command == sscf_pkg::CMD_DOTS);
      pad   <= cmd.pad_byte;
      mask  <= cmd.dot_mask;
    end else if (busy && !done) begin
      shreg <= shreg << sscf_pkg::BITS_PER_STEP;
      bcd   <= sscf_pkg::dabble_step(bcd,
                 shreg[sscf_pkg::NUMBER_W-1 -: sscf_pkg::BITS_PER_STEP]);
    end
  end

  // digit count from the highest non-zero bcd digit
  always_comb begin
    nd = '0;
    for (int i = 0; i < sscf_pkg::BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        nd = sscf_pkg::ND_W'(i + 1);
      end
    end
    wide = (int'(nd) > DIGIT_COUNT - int'(neg));
  end

  always_comb begin
    push_data.neg    = neg;
    push_data.nd     = nd;
    push_data.pad    = pad;
    push_data.digits = bcd;
    push_data.mask   = mask;
    if (dots) begin
      push_data.kind = sscf_pkg::KIND_DOTS;
    end else if (nd == '0) begin
      push_data.kind = sscf_pkg::KIND_ZERO;
    end else if (wide) begin
      push_data.kind = sscf_pkg::KIND_WIDE;
    end else begin
      push_data.kind = sscf_pkg::KIND_NUM;
    end
  end

  `SSCF_ASSERT_NXT(a_conv_advances, busy && !done, busy && (cnt == $past(cnt) + 3'd1), "conversion step lost")
  `SSCF_ASSERT_IMP(a_num_fits, push_valid && (push_data.kind == sscf_pkg::KIND_NUM), (push_data.nd != '0) && (int'(push_data.nd) <= DIGIT_COUNT), "number beat does not fit the display")
  `SSCF_ASSERT_IMP(a_wide_nonzero, push_valid && (push_data.kind == sscf_pkg::KIND_WIDE), push_data.nd != '0, "overflow beat with zero magnitude")

endmodule

`default_nettype wire

// ===== src/sscf_queue.sv =====
// ----------------------------------------------------------------------------
// sscf_queue
// short fifo of classified commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sscf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  sscf_pkg::entry_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sscf_pkg::entry_t  pop_data
);

  localparam logic [sscf_pkg::PTR_W-1:0]   LAST_PTR = sscf_pkg::PTR_W'(sscf_pkg::QUEUE_DEPTH - 1);
  localparam logic [sscf_pkg::COUNT_W-1:0] FULL_CNT = sscf_pkg::COUNT_W'(sscf_pkg::QUEUE_DEPTH);

  sscf_pkg::entry_t               slots [sscf_pkg::QUEUE_DEPTH];
  logic [sscf_pkg::PTR_W-1:0]     wr_ptr;
  logic [sscf_pkg::PTR_W-1:0]     rd_ptr;
  logic [sscf_pkg::COUNT_W-1:0]   count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/sscf_back.sv =====
// ----------------------------------------------------------------------------
// sscf_back
// walks the queued command byte by byte into a registered output beat
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_command_formatter_unit_macros.svh"

module sscf_back #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  output logic              head_pop,
  input  sscf_pkg::entry_t  head,
  sscf_byte_if.source       disp
);

  localparam int MAX_LEN = (DIGIT_COUNT + 2 > 6) ? DIGIT_COUNT + 2 : 6;
  localparam int POS_W   = $clog2(MAX_LEN);

  logic [POS_W-1:0]              pos;
  logic                          out_valid;
  logic [sscf_pkg::BYTE_W-1:0]   out_data;
  logic                          out_last;

  logic [POS_W-1:0]              last_idx;
  logic                          is_last;
  logic                          load;
  logic [sscf_pkg::BYTE_W-1:0]   next_byte;

  assign disp.valid    = out_valid;
  assign disp.out_byte = out_data;
  assign disp.last     = out_last;

  assign load     = head_valid && (!out_valid || disp.ready);
  assign is_last  = (pos == last_idx);
  assign head_pop = load && is_last;

  always_comb begin
    case (head.kind)
      sscf_pkg::KIND_DOTS: last_idx = POS_W'(1);
      sscf_pkg::KIND_ZERO: last_idx = POS_W'(DIGIT_COUNT + 1);
      sscf_pkg::KIND_WIDE: last_idx = POS_W'(5);
      sscf_pkg::KIND_NUM:  last_idx = POS_W'(DIGIT_COUNT);
      default:             last_idx = POS_W'(DIGIT_COUNT);
    endcase
  end

  always_comb begin
    int p;
    int j;
    int left;
    int k;
    p         = int'(pos);
    j         = p - 1;
    left      = DIGIT_COUNT - int'(head.nd);
    k         = DIGIT_COUNT - 1 - j;
    next_byte = head.pad;
    case (head.kind)
      sscf_pkg::KIND_DOTS: begin
        next_byte = (p == 0) ? sscf_pkg::CHR_W : {2'b00, head.mask};
      end
      sscf_pkg::KIND_ZERO: begin
        if (p < 2) begin
          next_byte = sscf_pkg::CHR_V;
        end else if (p == DIGIT_COUNT + 1) begin
          next_byte = sscf_pkg::CHR_ZERO;
        end else begin
          next_byte = head.pad;
        end
      end
      sscf_pkg::KIND_WIDE: begin
        if (p < 2) begin
          next_byte = sscf_pkg::CHR_V;
        end else if (p == 3) begin
          next_byte = sscf_pkg::CHR_ZERO;
        end else if (p == 4) begin
          next_byte = sscf_pkg::CHR_F;
        end else begin
          next_byte = sscf_pkg::CHR_MINUS;
        end
      end
      sscf_pkg::KIND_NUM: begin
        if (p == 0) begin
          next_byte = sscf_pkg::CHR_V;
        end else if (j < left) begin
          next_byte = (j == left - 1 && head.neg) ? sscf_pkg::CHR_MINUS : head.pad;
        end else if (k >= 0 && k < sscf_pkg::BCD_DIGITS) begin
          next_byte = sscf_pkg::CHR_ZERO + {4'b0000, head.digits[3'(k)]};
        end else begin
          next_byte = sscf_pkg::CHR_ZERO;
        end
      end
      default: next_byte = head.pad;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= is_last ? '0 : pos + 1'b1;
    end else if (disp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= next_byte;
      out_last <= is_last;
    end
  end

  `SSCF_ASSERT_IMP(a_beat_from_queue, $rose(out_valid), $past(head_valid), "beat shown with no queued command")
  `SSCF_ASSERT_IMP(a_pos_idle, !head_valid, pos == '0, "byte position not rewound")
  `SSCF_ASSERT_IMP(a_pos_bound, head_valid, pos <= last_idx, "byte position past end of sequence")

endmodule

`default_nettype wire

// ===== src/seven_segment_command_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// seven_segment_command_formatter_unit
// command to byte stream formatter for a serial seven-segment display
// ----------------------------------------------------------------------------
// A command beat becomes a run of display bytes, one per cycle while a
// command is queued and the display is ready, with last set on the final
// byte: a dots command gives two bytes, a number command gives DIGIT_COUNT+1
// bytes (DIGIT_COUNT+2 for zero, six when it does not fit). The front
// converts a number with a load and four 4-bit double-dabble steps and
// takes a dots command with its load alone; a two-entry queue lets it run
// ahead of the back, which emits exactly one byte per cycle through a
// registered output while a command waits and the display is ready.
// The front takes the next command in the same cycle as it hands the
// current one to the queue, and the first byte of a command reaches the
// registered output only after its conversion and the queue.
`default_nettype none

module seven_segment_command_formatter_unit #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst,
  sscf_cmd_if.sink    cmd,
  sscf_byte_if.source disp
);

  logic              push_valid;
  logic              push_ready;
  sscf_pkg::entry_t  push_data;
  logic              head_valid;
  logic              head_pop;
  sscf_pkg::entry_t  head;

  sscf_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sscf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head)
  );

  sscf_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head       (head),
    .disp       (disp)
  );

endmodule

`default_nettype wire
